// ===== rtl/cfc_pkg.sv =====
package cfc_pkg;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 24;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned FRAME_W   = 24;
  localparam int unsigned MAG_W     = 20;
  localparam int unsigned TIME_W    = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MAG   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_SEL  = 8'd3;

  localparam logic [15:0] RST_FRAME_GAP = 16'd2000;
  localparam logic [23:0] RST_TIMEOUT   = 24'd300000;
  localparam logic [19:0] RST_MAX_MAG   = 20'd60000;
  localparam logic [1:0]  RST_TERM_SEL  = 2'd0;

  localparam logic [1:0] TERM_ENTER = 2'd1;
  localparam logic [1:0] TERM_TAB   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_CHAR     = 2'd0;
  localparam logic [1:0] STAT_NO_FRAME = 2'd1;
  localparam logic [1:0] STAT_STALE    = 2'd2;

  // Frame bit positions
  localparam int unsigned SIGN_BIT = 20;
  localparam int unsigned UNIT_BIT = 23;

  typedef struct packed {
    logic [15:0] frame_gap;
    logic [23:0] timeout;
    logic [19:0] max_mag;
    logic [1:0]  term_sel;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_FORMAT,
    JOB_NO_FRAME,
    JOB_STALE
  } job_kind_e;

  typedef struct packed {
    job_kind_e            kind;
    logic [FRAME_W-1:0]   frame;
  } job_t;

endpackage

// ===== rtl/cfc_front.sv =====
module cfc_front
  import cfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic        data_bit_i,
  input  logic [TIME_W-1:0] now_i,
  input  logic        q_full_i,
  output logic        push_o,
  output job_t        push_job_o
);

  logic [ACC_W-1:0]   accum_q, accum_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [TIME_W-1:0]  last_edge_q, last_edge_d;
  logic [FRAME_W-1:0] held_frame_q, held_frame_d;
  logic               held_valid_q, held_valid_d;
  logic [TIME_W-1:0]  held_time_q, held_time_d;

  logic               accept;
  logic [TIME_W-1:0]  gap;
  logic [TIME_W-1:0]  age;
  logic               close;
  logic               plausible;
  logic [ACC_W-1:0]   acc_base;
  logic [CNT_W-1:0]   cnt_base;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign gap       = now_i - last_edge_q;
  assign age       = now_i - held_time_q;
  assign close     = gap > {16'd0, cfg_i.frame_gap};
  assign plausible = (accum_q[22:21] == 2'b00) && (accum_q[MAG_W-1:0] <= cfg_i.max_mag);
  assign acc_base  = close ? '0 : accum_q;
  assign cnt_base  = close ? '0 : count_q;

  always_comb begin
    accum_d      = accum_q;
    count_d      = count_q;
    last_edge_d  = last_edge_q;
    held_frame_d = held_frame_q;
    held_valid_d = held_valid_q;
    held_time_d  = held_time_q;
    push_o       = 1'b0;
    push_job_o.kind  = JOB_FORMAT;
    push_job_o.frame = held_frame_q;

    if (accept && !cmd_i) begin
      last_edge_d = now_i;
      if (close && (count_q >= CNT_W'(FRAME_LEN)) && plausible) begin
        held_frame_d = accum_q[FRAME_W-1:0];
        held_valid_d = 1'b1;
        held_time_d  = now_i;
      end
      accum_d = acc_base;
      count_d = cnt_base;
      // The accumulator saturates: bits past the last position are dropped.
      if (cnt_base < CNT_W'(ACC_W)) begin
        accum_d = acc_base | ({{(ACC_W-1){1'b0}}, data_bit_i} << cnt_base[CNT_W-2:0]);
        count_d = cnt_base + 1'b1;
      end
    end

    if (accept && cmd_i) begin
      push_o = 1'b1;
      if (!held_valid_q) begin
        push_job_o.kind = JOB_NO_FRAME;
      end else if (age > {8'd0, cfg_i.timeout}) begin
        push_job_o.kind = JOB_STALE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q      <= '0;
      count_q      <= '0;
      last_edge_q  <= '0;
      held_frame_q <= '0;
      held_valid_q <= 1'b0;
      held_time_q  <= '0;
    end else begin
      accum_q      <= accum_d;
      count_q      <= count_d;
      last_edge_q  <= last_edge_d;
      held_frame_q <= held_frame_d;
      held_valid_q <= held_valid_d;
      held_time_q  <= held_time_d;
    end
  end

endmodule

// ===== rtl/cfc_queue.sv =====
module cfc_queue
  import cfc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t pop_job_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== rtl/cfc_back.sv =====
module cfc_back
  import cfc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       q_empty_i,
  input  job_t       q_job_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic [1:0] out_status_o,
  output logic       out_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_BCD,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PH_SIGN,
    PH_INT,
    PH_DOT,
    PH_FRAC,
    PH_TERM,
    PH_ERR
  } phase_e;

  localparam logic [11:0] DIV_MM   = 12'd100;
  localparam logic [11:0] DIV_INCH = 12'd2000;
  // Reciprocals 2^27/100 and 2^31/2000, rounded up; exact for every 20-bit magnitude.
  localparam logic [20:0] RECIP_MM   = 21'd1342178;
  localparam logic [20:0] RECIP_INCH = 21'd1073742;
  localparam logic [4:0]  DIV_STEPS = 5'd2;
  localparam logic [4:0]  BCD_STEPS = 5'd14;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_MINUS = 8'h2D;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_ENTER = 8'd10;
  localparam logic [7:0]  CH_TAB   = 8'd9;

  state_e            state_q;
  phase_e            phase_q;
  logic [4:0]        step_q;
  logic [2:0]        idx_q;
  logic              inch_q;
  logic              neg_q;
  logic [1:0]        err_q;
  logic [MAG_W-1:0]  mag_q;
  logic [10:0]       rem_q;
  logic [13:0]       ibin_q, fbin_q;
  logic [4:0][3:0]   ibcd_q, fbcd_q;

  logic              out_valid_q;
  logic [7:0]        out_char_q;
  logic [1:0]        out_status_q;
  logic              out_last_q;

  logic [11:0]       divisor;
  logic [20:0]       recip;
  logic [40:0]       prod;
  logic [13:0]       quot;
  logic [25:0]       qprod;
  logic [19:0]       rem_full;
  logic [4:0][3:0]   iadj, fadj;
  logic [2:0]        top_idx;
  logic              out_free;
  logic              emit_go;
  logic              term_en;
  logic [7:0]        emit_char;
  logic [1:0]        emit_status;
  logic              emit_last;
  logic [FRAME_W-1:0] jf;

  // Add-3 correction of every BCD digit before the shift.
  function automatic logic [4:0][3:0] dabble(input logic [4:0][3:0] b);
    logic [4:0][3:0] r;
    for (int i = 0; i < 5; i++) begin
      r[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
    end
    return r;
  endfunction

  assign jf       = q_job_i.frame;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;
  assign divisor  = inch_q ? DIV_INCH : DIV_MM;
  assign recip    = inch_q ? RECIP_INCH : RECIP_MM;
  assign prod     = {21'd0, mag_q} * {20'd0, recip};
  assign quot     = inch_q ? {4'd0, prod[40:31]} : prod[40:27];
  assign qprod    = {12'd0, ibin_q} * {14'd0, divisor};
  assign rem_full = mag_q - qprod[19:0];
  assign iadj     = dabble(ibcd_q);
  assign fadj     = dabble(fbcd_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = (state_q == ST_EMIT) && !((phase_q == PH_INT) && (idx_q == 3'd7)) &&
                    out_free;
  assign term_en  = (cfg_i.term_sel == TERM_ENTER) || (cfg_i.term_sel == TERM_TAB);

  always_comb begin
    if (ibcd_q[4] != 4'd0) begin
      top_idx = 3'd4;
    end else if (ibcd_q[3] != 4'd0) begin
      top_idx = 3'd3;
    end else if (ibcd_q[2] != 4'd0) begin
      top_idx = 3'd2;
    end else if (ibcd_q[1] != 4'd0) begin
      top_idx = 3'd1;
    end else begin
      top_idx = 3'd0;
    end
  end

  always_comb begin
    emit_status = STAT_CHAR;
    emit_last   = 1'b0;
    case (phase_q)
      PH_SIGN: emit_char = CH_MINUS;
      PH_INT:  emit_char = CH_ZERO + {4'd0, ibcd_q[idx_q]};
      PH_DOT:  emit_char = CH_DOT;
      PH_FRAC: begin
        emit_char = CH_ZERO + {4'd0, fbcd_q[idx_q]};
        emit_last = (idx_q == 3'd0) && !term_en;
      end
      PH_TERM: begin
        emit_char = (cfg_i.term_sel == TERM_TAB) ? CH_TAB : CH_ENTER;
        emit_last = 1'b1;
      end
      PH_ERR: begin
        emit_char   = 8'd0;
        emit_status = err_q;
        emit_last   = 1'b1;
      end
      default: emit_char = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_ERR;
      step_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            inch_q <= jf[UNIT_BIT];
            neg_q  <= jf[SIGN_BIT] && (jf[MAG_W-1:0] != '0);
            mag_q  <= jf[MAG_W-1:0];
            rem_q  <= '0;
            step_q <= DIV_STEPS;
            case (q_job_i.kind)
              JOB_NO_FRAME: begin
                err_q   <= STAT_NO_FRAME;
                phase_q <= PH_ERR;
                state_q <= ST_EMIT;
              end
              JOB_STALE: begin
                err_q   <= STAT_STALE;
                phase_q <= PH_ERR;
                state_q <= ST_EMIT;
              end
              default: state_q <= ST_DIV;
            endcase
          end
        end
        ST_DIV: begin
          // Quotient by reciprocal multiply; remainder in the next cycle.
          if (step_q == DIV_STEPS) begin
            ibin_q <= quot;
          end else begin
            rem_q   <= rem_full[10:0];
            state_q <= ST_BCD;
          end
          step_q <= step_q - 5'd1;
        end
        ST_BCD: begin
          if (step_q == 5'd0) begin
            fbin_q <= inch_q ? ({1'b0, rem_q, 2'b00} + {3'b000, rem_q}) : {3'b000, rem_q};
            ibcd_q <= '0;
            fbcd_q <= '0;
            step_q <= BCD_STEPS;
          end else begin
            ibcd_q <= 20'({iadj, ibin_q[13]});
            fbcd_q <= 20'({fadj, fbin_q[13]});
            ibin_q <= {ibin_q[12:0], 1'b0};
            fbin_q <= {fbin_q[12:0], 1'b0};
            step_q <= step_q - 5'd1;
            if (step_q == 5'd1) begin
              state_q <= ST_EMIT;
              phase_q <= neg_q ? PH_SIGN : PH_INT;
            end
          end
        end
        ST_EMIT: begin
          if ((phase_q == PH_INT) && (idx_q == 3'd7)) begin
            idx_q <= top_idx;
          end else if (out_free) begin
            out_valid_q  <= 1'b1;
            out_char_q   <= emit_char;
            out_status_q <= emit_status;
            out_last_q   <= emit_last;
            if (emit_last) begin
              state_q <= ST_IDLE;
            end
            case (phase_q)
              PH_SIGN: phase_q <= PH_INT;
              PH_INT: begin
                if (idx_q == 3'd0) begin
                  phase_q <= PH_DOT;
                end else begin
                  idx_q <= idx_q - 3'd1;
                end
              end
              PH_DOT: begin
                phase_q <= PH_FRAC;
                idx_q   <= inch_q ? 3'd3 : 3'd1;
              end
              PH_FRAC: begin
                if (idx_q != 3'd0) begin
                  idx_q <= idx_q - 3'd1;
                end else if (term_en) begin
                  phase_q <= PH_TERM;
                end
              end
              default: phase_q <= PH_ERR;
            endcase
            if (emit_last) begin
              idx_q <= 3'd7;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      // Marks the integer digit index as not yet set for the next reading.
      if ((state_q == ST_IDLE) && !q_empty_i) begin
        idx_q <= 3'd7;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_char_o   = out_char_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== rtl/caliper_frame_capture_and_format.sv =====
// Clock edge beats yield no result; one beat per cycle is accepted while the two-entry
// request queue has room.
// A type request is queued, popped when the back end is idle, divided by a reciprocal
// multiply and converted to BCD; an optional minus sign, its digits, point and optional
// terminator follow in order while the output accepts them; no new request is popped
// before the last character is registered. Errors (no frame, stale) skip both steps.
// Reset clears all capture state and the queue and loads the register defaults.
module caliper_frame_capture_and_format
  import cfc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [39:0]           s_axis_tdata_i,   // data_bit [0], now_us [32:1], zero [39:33]
  input  logic                  s_axis_tuser_i,   // cmd [0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // char_code [7:0]
  output logic [1:0]            m_axis_tuser_o,   // status [1:0]
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic push, q_full, q_empty, pop;
  job_t push_job, pop_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_gap <= RST_FRAME_GAP;
      cfg_q.timeout   <= RST_TIMEOUT;
      cfg_q.max_mag   <= RST_MAX_MAG;
      cfg_q.term_sel  <= RST_TERM_SEL;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_GAP: cfg_q.frame_gap <= cfg_data_i[15:0];
        REG_TIMEOUT:   cfg_q.timeout   <= cfg_data_i[23:0];
        REG_MAX_MAG:   cfg_q.max_mag   <= cfg_data_i[19:0];
        REG_TERM_SEL:  cfg_q.term_sel  <= cfg_data_i[1:0];
        default:       cfg_q <= cfg_q;
      endcase
    end
  end

  cfc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .cmd_i      (s_axis_tuser_i),
    .data_bit_i (s_axis_tdata_i[0]),
    .now_i      (s_axis_tdata_i[32:1]),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_job_o (push_job)
  );

  cfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (pop),
    .pop_job_o  (pop_job),
    .empty_o    (q_empty)
  );

  cfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_empty_i    (q_empty),
    .q_job_i      (pop_job),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

// ===== tb/tb_caliper_frame_capture_and_format.sv =====
`timescale 1ns / 100ps

module tb_caliper_frame_capture_and_format;
  import cfc_pkg::*;

  localparam bit CMD_EDGE = 1'b0;
  localparam bit CMD_TYPE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd7;

  localparam logic [7:0] KEY_ZERO  = 8'h30;
  localparam logic [7:0] KEY_MINUS = 8'h2D;
  localparam logic [7:0] KEY_POINT = 8'h2E;
  localparam logic [7:0] KEY_ENTER = 8'd10;
  localparam logic [7:0] KEY_TAB   = 8'd9;

  // A request keeps the formatter busy until its last character is registered.
  localparam int SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] stat;
    logic       fin;
  } key_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [39:0]           s_axis_tdata_i = '0;   // data_bit [0], now_us [32:1], zero [39:33]
  logic                  s_axis_tuser_i = 1'b0; // cmd [0]
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [7:0]            m_axis_tdata_o;        // char_code [7:0]
  logic [1:0]            m_axis_tuser_o;        // status [1:0]
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  caliper_frame_capture_and_format u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies, as the block should hold them.
  bit [15:0] gap_us     = RST_FRAME_GAP;
  bit [23:0] timeout_us = RST_TIMEOUT;
  bit [19:0] max_mag    = RST_MAX_MAG;
  bit [1:0]  term_sel   = RST_TERM_SEL;

  // Capture state mirror.
  bit [31:0] shift_word;
  bit [5:0]  shift_count;
  bit [31:0] last_edge_us;
  bit [23:0] held_word;
  bit        held_ok;
  bit [31:0] held_at;

  key_t expected_keys[$];
  key_t reading[$];

  int        mismatches;
  int        beats_sent;
  int        snd_idle_pct;
  int        rcv_stall_pct;
  bit [31:0] clock_us;

  function automatic void add_key(logic [7:0] code);
    reading.push_back('{code, STAT_CHAR, 1'b0});
  endfunction

  function automatic void add_digits(bit [31:0] v, int mindig);
    bit [7:0] dig[10];
    int       n;
    n = 0;
    do begin
      dig[n] = KEY_ZERO + 8'(v % 10);
      v = v / 10;
      n++;
    end while (v != 0 && n < 10);
    while (n < mindig) begin
      dig[n] = KEY_ZERO;
      n++;
    end
    for (int i = n - 1; i >= 0; i--) add_key(dig[i]);
  endfunction

  // Advances the mirror by one accepted beat and queues the keys it should produce.
  function automatic void capture_beat(bit cmd, bit dbit, bit [31:0] stamp);
    bit [31:0] gap;
    bit [31:0] mag;
    if (cmd == CMD_EDGE) begin
      gap = stamp - last_edge_us;
      last_edge_us = stamp;
      if (gap > 32'(gap_us)) begin
        if (shift_count >= FRAME_LEN && shift_word[22:21] == 2'b00 &&
            shift_word[19:0] <= max_mag) begin
          held_word = shift_word[23:0];
          held_ok   = 1'b1;
          held_at   = stamp;
        end
        shift_word  = '0;
        shift_count = '0;
      end
      if (shift_count < 32) begin
        shift_word[shift_count[4:0]] = dbit;
        shift_count++;
      end
    end else begin
      reading.delete();
      if (!held_ok) begin
        reading.push_back('{8'd0, STAT_NO_FRAME, 1'b1});
      end else if (stamp - held_at > 32'(timeout_us)) begin
        reading.push_back('{8'd0, STAT_STALE, 1'b1});
      end else begin
        mag = 32'(held_word[19:0]);
        if (held_word[SIGN_BIT] && mag != 0) add_key(KEY_MINUS);
        if (held_word[UNIT_BIT]) begin
          add_digits(mag / 2000, 1);
          add_key(KEY_POINT);
          add_digits((mag % 2000) * 5, 4);
        end else begin
          add_digits(mag / 100, 1);
          add_key(KEY_POINT);
          add_digits(mag % 100, 2);
        end
        if (term_sel == TERM_ENTER) add_key(KEY_ENTER);
        else if (term_sel == TERM_TAB) add_key(KEY_TAB);
        reading[reading.size() - 1].fin = 1'b1;
      end
      foreach (reading[i]) expected_keys.push_back(reading[i]);
    end
  endfunction

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin : check_keys
    key_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_keys.size() == 0) begin
        $error("unexpected key: char_code 0x%0h status %0d last %0b",
               m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatches++;
      end else begin
        want = expected_keys.pop_front();
        if (m_axis_tdata_o !== want.code) begin
          $error("char_code: expected 0x%0h, got 0x%0h", want.code, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want.stat) begin
          $error("status: expected %0d, got %0d", want.stat, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.fin) begin
          $error("last: expected %0b, got %0b", want.fin, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_beat(input bit cmd, input bit dbit, input bit [31:0] stamp);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, stamp, dbit};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    capture_beat(cmd, dbit, stamp);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (expected_keys.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input bit [23:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_FRAME_GAP: gap_us     = value[15:0];
      REG_TIMEOUT:   timeout_us = value[23:0];
      REG_MAX_MAG:   max_mag    = value[19:0];
      REG_TERM_SEL:  term_sel   = value[1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input bit [15:0] gap, input bit [23:0] tmo,
                         input bit [19:0] mag, input bit [1:0] term);
    set_register(REG_FRAME_GAP, 24'(gap));
    set_register(REG_TIMEOUT, tmo);
    set_register(REG_MAX_MAG, 24'(mag));
    set_register(REG_TERM_SEL, 24'(term));
  endtask

  // The first edge follows the previous one by first_step, the rest stay inside the gap.
  task automatic send_frame(input bit [39:0] word, input int len, input bit [31:0] first_step);
    for (int i = 0; i < len; i++) begin
      clock_us += (i == 0) ? first_step : 32'($urandom_range(0, gap_us));
      send_beat(CMD_EDGE, word[i], clock_us);
    end
  endtask

  function automatic bit [31:0] boundary_step();
    return 32'(gap_us) + 1 + $urandom_range(0, 5000);
  endfunction

  // One edge past the gap limit, so the frame in progress gets judged.
  task automatic close_frame();
    clock_us += boundary_step();
    send_beat(CMD_EDGE, 1'($urandom_range(0, 1)), clock_us);
  endtask

  task automatic send_request();
    bit [31:0] age;
    case ($urandom_range(0, 5))
      0:       age = 0;
      1:       age = 32'(timeout_us);
      2:       age = 32'(timeout_us) + 1;
      3:       age = $urandom_range(0, timeout_us);
      4:       age = $urandom;
      default: age = clock_us - held_at;
    endcase
    send_beat(CMD_TYPE, 1'($urandom_range(0, 1)), held_at + age);
  endtask

  function automatic bit [39:0] random_frame_word();
    bit [39:0] w;
    w = 40'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0:       w[19:0] = 20'd0;
      1:       w[19:0] = max_mag;
      2:       w[19:0] = max_mag + 20'd1;
      3:       w[19:0] = 20'hFFFFF;
      default: w[19:0] = 20'($urandom_range(0, max_mag));
    endcase
    if ($urandom_range(0, 6) != 0) w[22:21] = 2'b00;
    return w;
  endfunction

  task automatic run_traffic(input int count);
    int stop;
    int len;
    stop = beats_sent + count;
    while (beats_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 9))
            0:       len = $urandom_range(1, 23);
            1:       len = $urandom_range(25, 40);
            default: len = FRAME_LEN;
          endcase
          send_frame(random_frame_word(), len, boundary_step());
          close_frame();
          repeat ($urandom_range(1, 3)) send_request();
        end
        6, 7: send_request();
        default: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0:       clock_us += 32'(gap_us);
              1:       clock_us += 32'(gap_us) + 1;
              2:       clock_us += $urandom;
              default: clock_us += $urandom_range(0, gap_us);
            endcase
            send_beat(CMD_EDGE, 1'($urandom_range(0, 1)), clock_us);
          end
        end
      endcase
    end
  endtask

  task automatic test_no_frame();
    send_beat(CMD_TYPE, 1'b1, $urandom);
  endtask

  task automatic test_directed_frames();
    // First edge lies within the gap of time zero, so no empty frame is closed.
    clock_us = 32'd0;
    send_frame(40'h0000_103039, FRAME_LEN, 32'd37);
    close_frame();
    send_beat(CMD_TYPE, 1'b0, held_at);
    send_beat(CMD_TYPE, 1'b1, held_at + 32'(timeout_us));
    send_beat(CMD_TYPE, 1'b0, held_at + 32'(timeout_us) + 1);
    // Long negative-zero inch frame across the timestamp wrap; extra bits are dropped.
    clock_us = 32'hFFFF_FF00;
    send_frame(40'hFF_A500_0000 | 40'h90_0000, 34, boundary_step());
    close_frame();
    send_beat(CMD_TYPE, 1'b1, held_at + 32'd5);
  endtask

  task automatic test_extreme_registers();
    set_all(16'd1, 24'hFF_FFFF, 20'hFFFFF, TERM_ENTER);
    send_frame(40'h80_FFFFF, FRAME_LEN, 32'd2);
    close_frame();
    send_beat(CMD_TYPE, 1'b0, held_at);
    send_frame(40'h0F_FFFF, FRAME_LEN, 32'd2);
    close_frame();
    send_beat(CMD_TYPE, 1'b1, held_at + 32'hFF_FFFF);
    run_traffic(50);
  endtask

  task automatic test_sender_gaps();
    set_all(16'hFFFF, 24'd1, 20'd0, TERM_TAB);
    snd_idle_pct = 65;
    run_traffic(55);
    snd_idle_pct = 0;
  endtask

  task automatic test_receiver_stalls();
    set_all(16'($urandom_range(1, 65535)), 24'($urandom_range(1, 24'hFF_FFFF)),
            20'($urandom_range(0, 20'hFFFFF)), 2'd3);
    set_register(REG_SPARE, 24'($urandom));
    rcv_stall_pct = 65;
    run_traffic(25);
    wait_drained();
    run_traffic(25);
    rcv_stall_pct = 0;
  endtask

  task automatic test_both_sides_idle();
    set_all(16'($urandom_range(1, 4000)), 24'($urandom_range(1000, 1000000)),
            20'($urandom_range(1000, 20'hFFFFF)), RST_TERM_SEL);
    snd_idle_pct  = 25;
    rcv_stall_pct = 25;
    run_traffic(55);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_frame();
    test_directed_frames();
    test_extreme_registers();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_sides_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS caliper_frame_capture_and_format");
    end else begin
      $display("FAIL caliper_frame_capture_and_format");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL caliper_frame_capture_and_format");
    $finish;
  end

endmodule
